// ===== rtl/core/trapezoid_speed_profile_assert.svh =====
// ----------------------------------------------------------------------------
// Trapezoid speed profile assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_SPEED_PROFILE_ASSERT_SVH
`define TRAPEZOID_SPEED_PROFILE_ASSERT_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tsp assertion failed");
`define TSP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tsp assertion failed");
`else
`define TSP_ASSERT(lbl, cond)
`define TSP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Trapezoid speed profile package
// Word constants, register indexes and the divide and square root steps.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int W        = 32;
  localparam int F        = 16;
  localparam int H        = W / 2;
  localparam int SR       = H + 4;
  localparam int AW       = 3;

  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_SPEED = 1'b1;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] lo;
    logic [W-1:0] q;
    logic         ovf;
  } div_t;

  typedef struct packed {
    logic [SR-1:0] rem;
    logic [H-1:0]  root;
  } sqrt_t;

  function automatic div_t div_step(div_t s, logic [W-1:0] d);
    logic [W:0] r2;
    div_t       o;
    r2 = {s.rem, s.lo[W-1]};
    o = s;
    o.lo = {s.lo[W-2:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      o.rem = W'(r2 - {1'b0, d});
      o.q   = {s.q[W-2:0], 1'b1};
    end else begin
      o.rem = r2[W-1:0];
      o.q   = {s.q[W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] bits);
    logic [SR-1:0] r;
    logic [SR-1:0] trial;
    sqrt_t         o;
    r     = {s.rem[SR-3:0], bits};
    trial = SR'({s.root, 2'b01});
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[H-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[H-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/trapezoid_speed_profile.sv =====
// ----------------------------------------------------------------------------
// Trapezoid speed profile
// Rest to rest move planner: phase times from distance and the limits.
// ----------------------------------------------------------------------------
// One distance is taken per cycle while the output is not stalled; its times
// pass through the product registers, the compare register, 32 bit-serial
// restoring divide stages, 16 square root stages and the output register.
// The whole pipeline advances together, so a stalled output holds every
// stage. Write the limits only while no transfer is in flight.
module trapezoid_speed_profile
  import tsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  distance,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [W-1:0]  total_time,
  output logic [W-1:0]  accel_end_time,
  output logic [W-1:0]  cruise_end_time,
  output logic          is_triangle
);

  logic [W-1:0]   accel_limit;
  logic [W-1:0]   speed_limit;
  logic           en;

  logic           p1_valid;
  logic [W-1:0]   p1_s;
  logic [2*W-1:0] p1_as;
  logic [2*W-1:0] p1_vv;

  logic           dv_valid [0:W];
  logic           dv_tri   [0:W];
  div_t           da       [0:W];
  div_t           db       [0:W];

  logic           sq_valid [1:H];
  logic           sq_tri   [1:H];
  logic [W-1:0]   sq_x     [1:H];
  logic [W-1:0]   sq_qb    [1:H];
  sqrt_t          sq_st    [1:H];

  logic [W-1:0]   sq_in_x;
  logic [W-1:0]   sq_in_qb;
  logic           tri_now;
  div_t           da_init;
  div_t           db_init;
  logic [W:0]     trap_sum;
  logic [W-1:0]   root_w;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_SPEED) ? speed_limit : accel_limit;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit <= W'(1) << F;
      speed_limit <= W'(1) << F;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SPEED) begin
        speed_limit <= pwdata;
      end else begin
        accel_limit <= pwdata;
      end
    end
  end

  always_comb begin
    tri_now = p1_as < p1_vv;
    if (tri_now) begin
      da_init.rem = p1_s;
      da_init.lo  = '0;
      da_init.ovf = p1_s >= accel_limit;
    end else begin
      da_init.rem = W'(speed_limit >> F);
      da_init.lo  = {speed_limit[F-1:0], {(W-F){1'b0}}};
      da_init.ovf = W'(speed_limit >> F) >= accel_limit;
    end
    da_init.q   = '0;
    db_init.rem = W'(p1_s >> F);
    db_init.lo  = {p1_s[F-1:0], {(W-F){1'b0}}};
    db_init.q   = '0;
    db_init.ovf = W'(p1_s >> F) >= speed_limit;
    sq_in_x  = da[W].ovf ? '1 : da[W].q;
    sq_in_qb = db[W].ovf ? '1 : db[W].q;
    trap_sum = {1'b0, sq_x[H]} + {1'b0, sq_qb[H]};
    root_w   = W'(sq_st[H].root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      for (int k = 0; k <= W; k++) begin
        dv_valid[k] <= 1'b0;
      end
      for (int j = 1; j <= H; j++) begin
        sq_valid[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid    <= in_valid;
      dv_valid[0] <= p1_valid;
      for (int k = 1; k <= W; k++) begin
        dv_valid[k] <= dv_valid[k-1];
      end
      sq_valid[1] <= dv_valid[W];
      for (int j = 2; j <= H; j++) begin
        sq_valid[j] <= sq_valid[j-1];
      end
      out_valid <= sq_valid[H];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_s  <= distance;
      p1_as <= (2*W)'(accel_limit) * (2*W)'(distance);
      p1_vv <= (2*W)'(speed_limit) * (2*W)'(speed_limit);
      dv_tri[0] <= tri_now;
      da[0]     <= da_init;
      db[0]     <= db_init;
      for (int k = 1; k <= W; k++) begin
        dv_tri[k] <= dv_tri[k-1];
        da[k]     <= div_step(da[k-1], accel_limit);
        db[k]     <= div_step(db[k-1], speed_limit);
      end
      sq_tri[1] <= dv_tri[W];
      sq_x[1]   <= sq_in_x;
      sq_qb[1]  <= sq_in_qb;
      sq_st[1]  <= sqrt_step('0, sq_in_x[W-1 -: 2]);
      for (int j = 2; j <= H; j++) begin
        sq_tri[j] <= sq_tri[j-1];
        sq_x[j]   <= sq_x[j-1];
        sq_qb[j]  <= sq_qb[j-1];
        sq_st[j]  <= sqrt_step(sq_st[j-1], sq_x[j-1][W+1-2*j -: 2]);
      end
      is_triangle <= sq_tri[H];
      if (sq_tri[H]) begin
        if (accel_limit == '0) begin
          total_time      <= '1;
          accel_end_time  <= '1;
          cruise_end_time <= '1;
        end else begin
          total_time      <= {root_w[W-2:0], 1'b0};
          accel_end_time  <= root_w;
          cruise_end_time <= root_w;
        end
      end else begin
        total_time      <= trap_sum[W] ? '1 : trap_sum[W-1:0];
        accel_end_time  <= sq_x[H];
        cruise_end_time <= sq_qb[H];
      end
    end
  end

`include "trapezoid_speed_profile_assert.svh"

  `TSP_ASSERT(a_tri_equal, out_valid && is_triangle |-> accel_end_time == cruise_end_time)
  `TSP_ASSERT(a_tri_root, out_valid && is_triangle && accel_end_time != '1 |-> accel_end_time[W-1:H] == '0)
  `TSP_ASSERT(a_trap_sum, out_valid && !is_triangle && total_time != '1 |-> total_time == W'(accel_end_time + cruise_end_time))
  `TSP_ASSERT_NEXT(a_stall_hold, !en, out_valid && $stable(total_time) && $stable(is_triangle))

endmodule
